// ===== design/mrqd_pkg.sv =====
// Shared constants, codes and types of the multilevel ready-queue dispatcher.
package mrqd_pkg;

  localparam int LEVELS      = 4;
  localparam int LEVEL_DEPTH = 8;
  localparam int PROC_COUNT  = 64;

  localparam int CMD_W   = 2;
  localparam int PID_W   = 6;
  localparam int PRIO_W  = 3;
  localparam int QUANT_W = 16;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SLOT_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);

  // Only ids that fit the id field can ever be marked.
  localparam int KILL_N = (PROC_COUNT < (1 << PID_W)) ? PROC_COUNT : (1 << PID_W);
  localparam int KILL_W = $clog2(KILL_N);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_KILL     = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    K_ENQUEUED   = 3'd0,
    K_DISPATCHED = 3'd1,
    K_REAPED     = 3'd2,
    K_BAD_PRIO   = 3'd3,
    K_LEVEL_FULL = 3'd4,
    K_NONE_READY = 3'd5,
    K_KILL_NOTED = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_KILL,
    ST_SCAN,
    ST_POP
  } state_e;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [QUANT_W-1:0] quantum;
  } entry_t;

  typedef struct packed {
    kind_e              kind;
    logic [PID_W-1:0]   out_proc_id;
    logic [QUANT_W-1:0] tick_load;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } lvl_ctl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] tail_slot;
  } lvl_stat_t;

endpackage

// ===== design/mrqd_req_if.sv =====
// Request channel: command beats into the dispatcher.
interface mrqd_req_if
  import mrqd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [PID_W-1:0]    proc_id;
  logic [PRIO_W-1:0]   priority_req;
  logic [QUANT_W-1:0]  quantum;

  modport source (output valid, cmd, proc_id, priority_req, quantum, input ready);
  modport sink   (input valid, cmd, proc_id, priority_req, quantum, output ready);
endinterface

// ===== design/mrqd_rsp_if.sv =====
// Response channel: result beats out of the dispatcher.
interface mrqd_rsp_if
  import mrqd_pkg::*;
();
  logic               valid;
  logic               ready;
  kind_e              kind;
  logic [PID_W-1:0]   out_proc_id;
  logic [QUANT_W-1:0] tick_load;
  logic               last;

  modport source (output valid, kind, out_proc_id, tick_load, last, input ready);
  modport sink   (input valid, kind, out_proc_id, tick_load, last, output ready);
endinterface

// ===== design/mrqd_entry_ram.sv =====
// Queue entry storage: one row of slots per level, registered read.
module mrqd_entry_ram
  import mrqd_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [LVL_W-1:0]  wr_lvl_i,
  input  logic [SLOT_W-1:0] wr_slot_i,
  input  entry_t            wr_data_i,
  input  logic              re_i,
  input  logic [LVL_W-1:0]  rd_lvl_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  output entry_t            rd_data_o
);

  entry_t mem [LEVELS][LEVEL_DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_lvl_i][wr_slot_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_q <= mem[rd_lvl_i][rd_slot_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== design/mrqd_level_table.sv =====
// Head and fill count of every level, seen through one selected level.
module mrqd_level_table
  import mrqd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] lvl_i,
  input  lvl_ctl_t         ctl_i,
  output lvl_stat_t        stat_o
);

  localparam int SUM_W = CNT_W + 1;

  logic [SLOT_W-1:0] head_q  [LEVELS];
  logic [SLOT_W-1:0] head_d  [LEVELS];
  logic [CNT_W-1:0]  count_q [LEVELS];
  logic [CNT_W-1:0]  count_d [LEVELS];

  logic [SLOT_W-1:0] head_sel;
  logic [CNT_W-1:0]  count_sel;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail_wrap;
  logic [SLOT_W-1:0] head_next;

  assign head_sel  = head_q[lvl_i];
  assign count_sel = count_q[lvl_i];
  assign tail_sum  = SUM_W'(head_sel) + SUM_W'(count_sel);
  assign tail_wrap = (tail_sum >= SUM_W'(LEVEL_DEPTH)) ? tail_sum - SUM_W'(LEVEL_DEPTH)
                                                       : tail_sum;
  assign head_next = (head_sel == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : head_sel + 1'b1;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.push) begin
      count_d[lvl_i] = count_sel + 1'b1;
    end else if (ctl_i.pop) begin
      head_d[lvl_i]  = head_next;
      count_d[lvl_i] = count_sel - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign stat_o.empty     = (count_sel == '0);
  assign stat_o.full      = (count_sel == CNT_W'(LEVEL_DEPTH));
  assign stat_o.head_slot = head_sel;
  assign stat_o.tail_slot = tail_wrap[SLOT_W-1:0];

endmodule

// ===== design/mrqd_kill_map.sv =====
// Kill marks, one bit per process id, single lookup/update port.
module mrqd_kill_map
  import mrqd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PID_W-1:0] pid_i,
  input  logic             set_i,
  input  logic             clr_i,
  output logic             killed_o
);

  logic [KILL_N-1:0] marks_q;
  logic [KILL_N-1:0] marks_d;
  logic              in_range;
  logic [KILL_W-1:0] idx;

  assign in_range = (32'(pid_i) < 32'(KILL_N));
  assign idx      = pid_i[KILL_W-1:0];
  assign killed_o = in_range && marks_q[idx];

  always_comb begin
    marks_d = marks_q;
    if (in_range && set_i) begin
      marks_d[idx] = 1'b1;
    end else if (in_range && clr_i) begin
      marks_d[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else begin
      marks_q <= marks_d;
    end
  end

endmodule

// ===== design/multilevel_ready_queue_dispatcher.sv =====
// Top level: request sequencer, level scan and result register of the dispatcher.
//
//  channel | dir | beat content                                 | accepted when
//  --------+-----+----------------------------------------------+---------------------
//  req_i   | in  | cmd, proc_id, priority_req, quantum          | req_i.valid & ready
//  rsp_o   | out | kind, out_proc_id, tick_load, last           | rsp_o.valid & ready
//
//  Enqueue and kill requests pass from the accepting idle state to their own
//  state, which loads the result register once the output register is free.
//  Dispatch scans from level 0 after the idle state: empty levels are
//  checked one per cycle by the shared level compare, and each pop is a read
//  of the entry RAM, followed by the pop state that emits its result.
//  A new request is accepted only in idle; a pending result waits in the
//  output register while the next request is taken, and a full register
//  holds the sequencer. Reset clears queue counts, kill marks and the
//  current process at once; no clearing pass is needed.
module multilevel_ready_queue_dispatcher
  import mrqd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mrqd_req_if.sink   req_i,
  mrqd_rsp_if.source rsp_o
);

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

  state_e state_q, state_d;

  // Latched request fields.
  logic [PID_W-1:0]   pid_q, pid_d;
  logic [PRIO_W-1:0]  prio_q, prio_d;
  logic [QUANT_W-1:0] quantum_q, quantum_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;

  // Current process.
  logic               cur_valid_q, cur_valid_d;
  logic [PID_W-1:0]   cur_pid_q, cur_pid_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q;
  rsp_t               rsp_d;
  logic               emit;
  logic               out_free;

  // Submodule links.
  lvl_ctl_t           lt_ctl;
  lvl_stat_t          lt_stat;
  logic               ram_we, ram_re;
  entry_t             ram_wdata, ram_rdata;
  logic [PID_W-1:0]   kill_pid;
  logic               kill_set, kill_clr, kill_hit;
  logic               prio_bad;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign prio_bad = (32'(prio_q) >= 32'(LEVELS));
  assign ram_wdata = '{pid: pid_q, quantum: quantum_q};
  // Check the popped entry while popping, the request id otherwise.
  assign kill_pid = (state_q == ST_POP) ? ram_rdata.pid : pid_q;

  mrqd_level_table u_level_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lvl_i  (lvl_q),
    .ctl_i  (lt_ctl),
    .stat_o (lt_stat)
  );

  mrqd_entry_ram u_entry_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_lvl_i  (lvl_q),
    .wr_slot_i (lt_stat.tail_slot),
    .wr_data_i (ram_wdata),
    .re_i      (ram_re),
    .rd_lvl_i  (lvl_q),
    .rd_slot_i (lt_stat.head_slot),
    .rd_data_o (ram_rdata)
  );

  mrqd_kill_map u_kill_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pid_i    (kill_pid),
    .set_i    (kill_set),
    .clr_i    (kill_clr),
    .killed_o (kill_hit)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.cmd)
            CMD_ENQUEUE:  state_d = ST_ENQ;
            CMD_DISPATCH: state_d = ST_SCAN;
            CMD_KILL:     state_d = ST_KILL;
            default:      state_d = ST_IDLE;  // unused command: drop it
          endcase
        end
      end
      ST_ENQ, ST_KILL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!lt_stat.empty) begin
          state_d = ST_POP;
        end else if (lvl_q == LAST_LVL && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          // A reaped entry keeps scanning at the same level; upper levels stay empty.
          state_d = kill_hit ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and results.
  always_comb begin
    pid_d       = pid_q;
    prio_d      = prio_q;
    quantum_d   = quantum_q;
    lvl_d       = lvl_q;
    cur_valid_d = cur_valid_q;
    cur_pid_d   = cur_pid_q;
    lt_ctl      = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    kill_set    = 1'b0;
    kill_clr    = 1'b0;
    emit        = 1'b0;
    rsp_d       = '{kind: K_ENQUEUED, out_proc_id: '0, tick_load: '0, last: 1'b1};

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          pid_d     = req_i.proc_id;
          prio_d    = req_i.priority_req;
          quantum_d = req_i.quantum;
          // Enqueue addresses its own level; dispatch scans from the top.
          lvl_d     = (req_i.cmd == CMD_ENQUEUE) ? req_i.priority_req[LVL_W-1:0] : '0;
        end
      end
      ST_ENQ: begin
        if (out_free) begin
          emit              = 1'b1;
          rsp_d.out_proc_id = pid_q;
          priority if (kill_hit) begin
            kill_clr   = 1'b1;
            rsp_d.kind = K_REAPED;
          end else if (prio_bad) begin
            rsp_d.kind = K_BAD_PRIO;
          end else if (lt_stat.full) begin
            rsp_d.kind = K_LEVEL_FULL;
          end else begin
            ram_we      = 1'b1;
            lt_ctl.push = 1'b1;
            rsp_d.kind  = K_ENQUEUED;
          end
        end
      end
      ST_KILL: begin
        if (out_free) begin
          emit              = 1'b1;
          kill_set          = 1'b1;
          rsp_d.kind        = K_KILL_NOTED;
          rsp_d.out_proc_id = pid_q;
        end
      end
      ST_SCAN: begin
        if (!lt_stat.empty) begin
          // Pop the head now; the entry shows up next cycle.
          ram_re     = 1'b1;
          lt_ctl.pop = 1'b1;
        end else if (lvl_q == LAST_LVL) begin
          if (out_free) begin
            emit       = 1'b1;
            rsp_d.kind = K_NONE_READY;
          end
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      ST_POP: begin
        if (out_free) begin
          emit              = 1'b1;
          rsp_d.out_proc_id = ram_rdata.pid;
          if (kill_hit) begin
            kill_clr   = 1'b1;
            rsp_d.kind = K_REAPED;
            rsp_d.last = 1'b0;
          end else begin
            cur_valid_d     = 1'b1;
            cur_pid_d       = ram_rdata.pid;
            rsp_d.kind      = K_DISPATCHED;
            rsp_d.tick_load = ram_rdata.quantum;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_d_hold: begin
      pid_q     <= pid_d;
      prio_q    <= prio_d;
      quantum_q <= quantum_d;
      lvl_q     <= lvl_d;
      cur_pid_q <= cur_pid_d;
      if (emit) begin
        out_q <= rsp_d;
      end
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.kind        = out_q.kind;
  assign rsp_o.out_proc_id = out_q.out_proc_id;
  assign rsp_o.tick_load   = out_q.tick_load;
  assign rsp_o.last        = out_q.last;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten");

  // Only a reap can be followed by more results of the same request.
  a_mid_is_reap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !rsp_d.last) |-> (rsp_d.kind == K_REAPED))
    else $error("non-final result that is not a reap");

  // Never write into a full level, never pop an empty one.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (lt_ctl.push && !lt_stat.full && !prio_bad))
    else $error("enqueue into full or invalid level");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lt_ctl.pop |-> (!lt_stat.empty && ram_re))
    else $error("pop from empty level");

  // A dispatch result makes that process current.
  a_current_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && rsp_d.kind == K_DISPATCHED) |=>
      (cur_valid_q && cur_pid_q == $past(rsp_d.out_proc_id)))
    else $error("current process not updated on dispatch");

endmodule

// ===== tb/tb_multilevel_ready_queue_dispatcher.sv =====
// Self-checking testbench of the multilevel ready-queue dispatcher.
`timescale 1ns / 1ps

module tb_multilevel_ready_queue_dispatcher;
  import mrqd_pkg::*;

  // The command field is two bits wide, and the block must ignore the fourth code.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int NUM_ROWS     = 25;
  localparam int RANDOM_ITEMS = 300;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_CYCLES  = 300;  // one long output stall
  localparam int HOLD_AFTER   = 40;   // results seen before that stall starts
  localparam int PAUSE_AT     = 180;  // random item at which the sender drains
  localparam int DRAIN_CYCLES = 100;  // quiet wait after the drain, for stray result beats
  localparam int CYCLE_LIMIT  = 400000;

  // One directed row. Where typed is set, the row's single result is written
  // out here and the predictor only tracks state. Otherwise the predictor decides.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PID_W-1:0]   pid;
    logic [PRIO_W-1:0]  prio;
    logic [QUANT_W-1:0] quantum;
    logic               typed;
    kind_e              kind;
  } row_t;

  localparam row_t PLAN [NUM_ROWS] = '{
    // after reset nothing is ready
    '{CMD_DISPATCH, 6'd0,  3'd0, 16'h0000, 1'b1, K_NONE_READY},
    // unused command: no result at all
    '{CMD_UNUSED,   6'd42, 3'd5, 16'hbeef, 1'b0, K_ENQUEUED},
    // kill, then enqueue of the killed id is reaped at once; then an out-of-range priority
    '{CMD_KILL,     6'd63, 3'd7, 16'hffff, 1'b1, K_KILL_NOTED},
    '{CMD_ENQUEUE,  6'd63, 3'd0, 16'h1234, 1'b1, K_REAPED},
    '{CMD_ENQUEUE,  6'd10, 3'd7, 16'hffff, 1'b1, K_BAD_PRIO},
    // fill the lowest level to the brim, then overflow it
    '{CMD_ENQUEUE,  6'd0,  3'd3, 16'h0000, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd1,  3'd3, 16'h0001, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd2,  3'd3, 16'h0000, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd3,  3'd3, 16'hffff, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd4,  3'd3, 16'h8000, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd5,  3'd3, 16'h7fff, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd6,  3'd3, 16'h00ff, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd7,  3'd3, 16'hff00, 1'b1, K_ENQUEUED},
    '{CMD_ENQUEUE,  6'd9,  3'd3, 16'h5555, 1'b1, K_LEVEL_FULL},
    '{CMD_KILL,     6'd0,  3'd0, 16'h0000, 1'b1, K_KILL_NOTED},
    '{CMD_KILL,     6'd1,  3'd0, 16'h0000, 1'b1, K_KILL_NOTED},
    '{CMD_ENQUEUE,  6'd63, 3'd0, 16'hffff, 1'b1, K_ENQUEUED},
    // top level first, then two reaps ahead of the first live process
    '{CMD_DISPATCH, 6'd0,  3'd0, 16'h0000, 1'b0, K_ENQUEUED},
    '{CMD_DISPATCH, 6'd63, 3'd7, 16'hffff, 1'b0, K_ENQUEUED},
    '{CMD_DISPATCH, 6'd0,  3'd0, 16'h0000, 1'b0, K_ENQUEUED},
    '{CMD_DISPATCH, 6'd21, 3'd2, 16'haaaa, 1'b0, K_ENQUEUED},
    // reap the rest so the dispatch runs dry
    '{CMD_KILL,     6'd5,  3'd0, 16'h0000, 1'b1, K_KILL_NOTED},
    '{CMD_KILL,     6'd6,  3'd0, 16'h0000, 1'b1, K_KILL_NOTED},
    '{CMD_KILL,     6'd7,  3'd0, 16'h0000, 1'b1, K_KILL_NOTED},
    '{CMD_DISPATCH, 6'd0,  3'd0, 16'h0000, 1'b0, K_ENQUEUED}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mrqd_req_if req_if ();
  mrqd_rsp_if rsp_if ();

  multilevel_ready_queue_dispatcher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tag that travels with each request beat: the result written in the table, if any.
  logic row_typed;
  rsp_t row_result;

  // Scheduler state as the testbench sees it.
  entry_t      ready_mem [LEVELS][LEVEL_DEPTH];
  int unsigned ready_head [LEVELS];
  int unsigned ready_cnt [LEVELS];
  bit          kill_mark [PROC_COUNT];
  bit          running_valid;
  logic [PID_W-1:0] running_pid;

  rsp_t pending_results [$];

  int errors;
  int n_sent;
  int n_results;
  int n_reaped;
  int n_dispatched;
  int n_full;
  int longest_chain;
  int cycles;
  bit sender_calm;

  function automatic rsp_t make_result(kind_e kind, logic [PID_W-1:0] pid,
                                       logic [QUANT_W-1:0] ticks);
    rsp_t r;
    r.kind        = kind;
    r.out_proc_id = pid;
    r.tick_load   = ticks;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic void clear_schedule();
    for (int l = 0; l < LEVELS; l++) begin
      ready_head[l] = 0;
      ready_cnt[l]  = 0;
    end
    for (int p = 0; p < PROC_COUNT; p++) kill_mark[p] = 1'b0;
    running_valid = 1'b0;
    running_pid   = '0;
  endfunction

  // Advance the scheduler state by one request; queue its results when keep is set.
  function automatic void schedule_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                           logic [PRIO_W-1:0] prio,
                                           logic [QUANT_W-1:0] quantum, bit keep);
    rsp_t   res [$];
    entry_t e;
    int     lv;
    bit     done;
    int     slot;
    case (cmd)
      CMD_ENQUEUE: begin
        if (pid < PROC_COUNT && kill_mark[pid]) begin
          kill_mark[pid] = 1'b0;
          res.push_back(make_result(K_REAPED, pid, '0));
        end else if (prio >= LEVELS) begin
          res.push_back(make_result(K_BAD_PRIO, pid, '0));
        end else if (ready_cnt[prio] >= LEVEL_DEPTH) begin
          res.push_back(make_result(K_LEVEL_FULL, pid, '0));
        end else begin
          slot = (ready_head[prio] + ready_cnt[prio]) % LEVEL_DEPTH;
          ready_mem[prio][slot].pid     = pid;
          ready_mem[prio][slot].quantum = quantum;
          ready_cnt[prio]++;
          res.push_back(make_result(K_ENQUEUED, pid, '0));
        end
      end
      CMD_DISPATCH: begin
        done = 1'b0;
        while (!done) begin
          lv = LEVELS;
          for (int l = LEVELS - 1; l >= 0; l--) if (ready_cnt[l] != 0) lv = l;
          if (lv == LEVELS) begin
            res.push_back(make_result(K_NONE_READY, '0, '0));
            done = 1'b1;
          end else begin
            e = ready_mem[lv][ready_head[lv]];
            ready_head[lv] = (ready_head[lv] + 1) % LEVEL_DEPTH;
            ready_cnt[lv]--;
            if (e.pid < PROC_COUNT && kill_mark[e.pid]) begin
              kill_mark[e.pid] = 1'b0;
              res.push_back(make_result(K_REAPED, e.pid, '0));
            end else begin
              running_valid = 1'b1;
              running_pid   = e.pid;
              res.push_back(make_result(K_DISPATCHED, e.pid, e.quantum));
              done = 1'b1;
            end
          end
        end
      end
      CMD_KILL: begin
        if (pid < PROC_COUNT) kill_mark[pid] = 1'b1;
        res.push_back(make_result(K_KILL_NOTED, pid, '0));
      end
      default: ;  // unused code: the block stays silent
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    if (res.size() > longest_chain) longest_chain = res.size();
    if (keep) foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  function automatic void check_field(string name, logic [QUANT_W-1:0] want,
                                      logic [QUANT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Check result beats against the oldest expectation, then predict from the
  // request beat of the same edge. A request can never answer on its own edge,
  // so checking first keeps the queue order independent of process order.
  always @(posedge clk_i) begin : scoreboard
    rsp_t want;
    if (!rst_ni) begin
      clear_schedule();
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat kind %0d id %0d ticks %0d", $time,
                   rsp_if.kind, rsp_if.out_proc_id, rsp_if.tick_load);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", QUANT_W'(want.kind), QUANT_W'(rsp_if.kind));
          check_field("out_proc_id", QUANT_W'(want.out_proc_id),
                      QUANT_W'(rsp_if.out_proc_id));
          check_field("tick_load", want.tick_load, rsp_if.tick_load);
          check_field("last", QUANT_W'(want.last), QUANT_W'(rsp_if.last));
          if (want.kind == K_REAPED) n_reaped++;
          if (want.kind == K_DISPATCHED) n_dispatched++;
          if (want.kind == K_LEVEL_FULL) n_full++;
        end
      end
      if (req_if.valid && req_if.ready) begin
        schedule_request(req_if.cmd, req_if.proc_id, req_if.priority_req,
                         req_if.quantum, !row_typed);
        if (row_typed) pending_results.push_back(row_result);
      end
    end
  end

  // Hard stop on a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one request beat and hold it until the block takes it.
  task automatic offer(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                       logic [PRIO_W-1:0] prio, logic [QUANT_W-1:0] quantum,
                       bit typed, rsp_t typed_result);
    while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.proc_id      <= pid;
    req_if.priority_req <= prio;
    req_if.quantum      <= quantum;
    row_typed           <= typed;
    row_result          <= typed_result;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (cmd != CMD_UNUSED) n_sent++;
  endtask

  // Mostly a small pool of ids, so kills land on queued processes; now and then any id.
  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(0, 3) == 0) return PID_W'($urandom_range(0, (1 << PID_W) - 1));
    return PID_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [QUANT_W-1:0] pick_quantum();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return QUANT_W'($urandom_range(0, (1 << QUANT_W) - 1));
    endcase
  endfunction

  // Request side: directed table, then random traffic with one full drain pause.
  initial begin : sender
    rsp_t typed_result;
    rsp_t no_result;
    logic [PRIO_W-1:0] prio;
    int   r;
    int   random_start;
    bit   paused;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_ENQUEUE;
    req_if.proc_id      <= '0;
    req_if.priority_req <= '0;
    req_if.quantum      <= '0;
    row_typed           <= 1'b0;
    row_result          <= '0;
    no_result = '0;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      typed_result = make_result(PLAN[i].kind,
                                 (PLAN[i].kind == K_NONE_READY) ? '0 : PLAN[i].pid, '0);
      typed_result.last = 1'b1;
      offer(PLAN[i].cmd, PLAN[i].pid, PLAN[i].prio, PLAN[i].quantum, PLAN[i].typed,
            typed_result);
    end

    random_start = n_sent;
    while (n_sent - random_start < RANDOM_ITEMS) begin
      // Keep one stretch of the sender busy on every cycle.
      sender_calm = (n_sent - random_start >= 60) && (n_sent - random_start < 120);
      if (!paused && n_sent - random_start >= PAUSE_AT) begin
        // Hold off until every outstanding result has come back.
        paused = 1'b1;
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
        // Kill sweep over the id pool, then one dispatch that reaps a long chain.
        for (int p = 0; p < 16; p++)
          offer(CMD_KILL, PID_W'(p), PRIO_W'($urandom), pick_quantum(), 1'b0, no_result);
        offer(CMD_DISPATCH, pick_pid(), PRIO_W'($urandom), pick_quantum(), 1'b0, no_result);
      end else if (r < 4) begin
        offer(CMD_UNUSED, pick_pid(), PRIO_W'($urandom), pick_quantum(), 1'b0, no_result);
      end else if (r < 46) begin
        prio = ($urandom_range(0, 9) == 0) ? PRIO_W'($urandom_range(LEVELS, 7))
                                           : PRIO_W'($urandom_range(0, LEVELS - 1));
        offer(CMD_ENQUEUE, pick_pid(), prio, pick_quantum(), 1'b0, no_result);
      end else if (r < 74) begin
        offer(CMD_DISPATCH, pick_pid(), PRIO_W'($urandom), pick_quantum(), 1'b0, no_result);
      end else begin
        offer(CMD_KILL, pick_pid(), PRIO_W'($urandom), pick_quantum(), 1'b0, no_result);
      end
    end
    req_if.valid <= 1'b0;
    sender_calm = 1'b0;
    // Let the last accepted beat reach the expectation queue first.
    @(posedge clk_i);

    // Drain: wait out every expectation, then give stray beats a chance to show.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d directed) and %0d result beats:", n_sent,
             random_start, n_results);
    $display("  %0d dispatches, %0d reaps, %0d level-full faults, longest chain %0d.",
             n_dispatched, n_reaped, n_full, longest_chain);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold that backs the block up,
  // and one stretch with ready held high.
  initial begin : receiver
    bit held;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_results >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (n_results >= 150 && n_results < 230) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

endmodule
